// ===== sv/fcr_pkg.sv =====
// Package for the feedback comb reverb: field widths, register codes,
// default sizes and fixed-point constants. No dependencies.
package fcr_pkg;

   // default sizes, handed to the top level's parameters
   localparam int CHANNELS_DEF    = 8;
   localparam int MAX_DELAY_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths
   localparam int CHANNEL_W   = 3;
   localparam int DLEN_W      = 13;
   localparam int GAIN_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // gain is unsigned Q2.14; product rounds half up
   localparam int GAIN_FRAC = 14;
   localparam int ROUND_ADD = 1 << (GAIN_FRAC - 1);

   // register reset values
   localparam logic              ENABLE_RESET = 1'b1;
   localparam logic [DLEN_W-1:0] DLEN_RESET   = '0;
   localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(8192);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ENABLE        = 2'd0,
      REG_DELAY_LENGTH  = 2'd1,
      REG_FEEDBACK_GAIN = 2'd2
   } csr_index_type;

endpackage

// ===== sv/fcr_ifs.sv =====
// Valid/ready channel interfaces of the feedback comb reverb: sample in,
// sample out, register write. Depends on fcr_pkg.
interface fcr_req_if import fcr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [CHANNEL_W-1:0]          channel;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, channel, sample_in, input ready);
   modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface fcr_rsp_if import fcr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [CHANNEL_W-1:0]          channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, channel_out, sample_out, input ready);
   modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

interface fcr_csr_if import fcr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fcr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fcr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/feedback_comb_reverb_core.sv =====
// Feedback comb reverb core, top level. Depends on fcr_pkg, the channel
// interfaces in fcr_ifs.sv and the generic RAM fcr_ram.
//
// Each sample transfer carries a channel tag. For an active channel the core
// reads the sample written one delay length earlier on that channel, computes
// y = x + round(gain * stored) (Q2.14 gain, ties round up), saturates y to the
// sample width, returns it and writes it back into the channel's ring. With
// enable low, delay_length zero or a channel beyond CHANNELS the sample passes
// through and no state changes. Rate: one sample per cycle while the input is
// not held off; the result passes through stage 1, stage 2 and the output
// register. One ring RAM read port and one write port set that rate. A
// sample is held off while the ring entry it reads is still being computed
// by a sample ahead of it: while that sample is in stage 1 (delay length 1
// with the same channel back to back), and for as long as the output stalls
// while that entry still waits in stage 2 for its write. Otherwise a stalled
// output does not block input while the pipeline has room. There is no clearing
// pass after reset or after a delay_length write: each channel has a wrapped
// flag, and until the channel's ring position first wraps, its reads return
// zero, which is what a cleared ring would hold. Writing delay_length resets
// all ring positions and wrapped flags. The user must write registers only
// while the core is idle (not enforced); the register channel is always ready.
module feedback_comb_reverb_core import fcr_pkg::*; #(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int MAX_DELAY   = MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   fcr_req_if.sink   req_bus,
   fcr_rsp_if.source rsp_bus,
   fcr_csr_if.sink   csr_bus
);

   localparam int POS_W    = $clog2(MAX_DELAY);
   localparam int LEN_W    = $clog2(MAX_DELAY + 1);
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W   = CH_IDX_W + POS_W;
   localparam int RAM_DEPTH = 2 ** ADDR_W;
   localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;

   // ---------------------------------------------------------------- registers
   logic              enable_ff, enable_in;
   logic [DLEN_W-1:0] dlen_ff, dlen_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   // ring position and wrapped flag per channel
   logic [POS_W-1:0]    pos_ff [CHANNELS];
   logic [POS_W-1:0]    pos_in [CHANNELS];
   logic [CHANNELS-1:0] wrap_ff, wrap_in;

   // stage 1: ring read in flight
   logic                          s1_v_ff, s1_v_in;
   logic                          s1_act_ff;
   logic                          s1_vld_ff;      // entry written since clear
   logic                          s1_fwd_ff;      // entry written at read edge
   logic signed [SAMPLE_BITS-1:0] s1_fwd_data_ff;
   logic [CHANNEL_W-1:0]          s1_ch_ff;
   logic signed [SAMPLE_BITS-1:0] s1_x_ff;
   logic [ADDR_W-1:0]             s1_addr_ff;

   // stage 2: product registered
   logic                          s2_v_ff, s2_v_in;
   logic                          s2_act_ff;
   logic [CHANNEL_W-1:0]          s2_ch_ff;
   logic signed [SAMPLE_BITS-1:0] s2_x_ff;
   logic [ADDR_W-1:0]             s2_addr_ff;
   logic signed [PROD_W-1:0]      s2_prod_ff;

   // output register
   logic                          rsp_v_ff, rsp_v_in;
   logic [CHANNEL_W-1:0]          rsp_ch_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_smp_ff;

   // ---------------------------------------------------------------- flow
   logic out_load, s2_free, s1_move, s1_free, accept, hazard;

   assign out_load = s2_v_ff && (!rsp_v_ff || rsp_bus.ready);
   assign s2_free  = !s2_v_ff || out_load;
   assign s1_move  = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s1_move;

   // ---------------------------------------------------------------- front end
   logic [LEN_W-1:0]    eff_len;
   logic [CH_IDX_W-1:0] ch_idx;
   logic                ch_in_range;
   logic                act_new;
   logic [POS_W-1:0]    pos_cur, pos_use, pos_next;
   logic [LEN_W:0]      pos_inc;
   logic                pos_wraps;
   logic [ADDR_W-1:0]   addr_new;

   // delay above the ring size acts as the ring size
   assign eff_len = (32'(dlen_ff) > MAX_DELAY) ? LEN_W'(MAX_DELAY) : LEN_W'(dlen_ff);

   assign ch_idx      = CH_IDX_W'(req_bus.channel);
   assign ch_in_range = 32'(req_bus.channel) < CHANNELS;
   assign act_new     = enable_ff && (eff_len != '0) && ch_in_range;

   assign pos_cur   = pos_ff[ch_idx];
   assign pos_use   = ((LEN_W + 1)'(pos_cur) >= (LEN_W + 1)'(eff_len)) ? '0 : pos_cur;
   assign pos_inc   = (LEN_W + 1)'(pos_use) + (LEN_W + 1)'(1);
   assign pos_wraps = pos_inc >= (LEN_W + 1)'(eff_len);
   assign pos_next  = pos_wraps ? '0 : POS_W'(pos_inc);
   assign addr_new  = {ch_idx, pos_use};

   // hold off while the entry is still pending in stage 1, or in stage 2
   // without being written at this edge
   assign hazard = act_new &&
                   ((s1_v_ff && s1_act_ff && (s1_addr_ff == addr_new)) ||
                    (s2_v_ff && s2_act_ff && (s2_addr_ff == addr_new) && !out_load));

   assign accept        = req_bus.valid && s1_free && !hazard;
   assign req_bus.ready = s1_free && !hazard;

   // ---------------------------------------------------------------- ring RAM
   logic                          wr_en;
   logic signed [SAMPLE_BITS-1:0] y_val;
   logic [SAMPLE_BITS-1:0]        rd_data;

   assign wr_en = out_load && s2_act_ff;

   fcr_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s2_addr_ff),
      .wr_data (y_val),
      .rd_en   (accept && act_new),
      .rd_addr (addr_new),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------- stage 1
   logic signed [SAMPLE_BITS-1:0] stored;
   logic signed [PROD_W-1:0]      prod;

   always_comb begin
      if (!s1_vld_ff) begin
         stored = '0;
      end else if (s1_fwd_ff) begin
         stored = s1_fwd_data_ff;
      end else begin
         stored = $signed(rd_data);
      end
   end

   // both operands widened to the full product width before the multiply
   assign prod = PROD_W'($signed({1'b0, gain_ff})) * PROD_W'(stored);

   // ---------------------------------------------------------------- stage 2
   logic signed [PROD_W-1:0] biased, rounded;
   logic signed [PROD_W:0]   sum;
   logic                     sum_ovf;

   assign biased  = s2_prod_ff + $signed(PROD_W'(ROUND_ADD));
   assign rounded = biased >>> GAIN_FRAC;
   assign sum     = (PROD_W + 1)'(s2_x_ff) + (PROD_W + 1)'(rounded);
   // overflow when the bits above the sample's sign bit disagree
   assign sum_ovf = !((&sum[PROD_W:SAMPLE_BITS-1]) || !(|sum[PROD_W:SAMPLE_BITS-1]));

   always_comb begin
      if (!s2_act_ff) begin
         y_val = s2_x_ff;
      end else if (sum_ovf) begin
         y_val = sum[PROD_W] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                             : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
         y_val = sum[SAMPLE_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      enable_in = enable_ff;
      dlen_in   = dlen_ff;
      gain_in   = gain_ff;
      pos_in    = pos_ff;
      wrap_in   = wrap_ff;

      if (accept && act_new) begin
         pos_in[ch_idx] = pos_next;
         if (pos_wraps) begin
            wrap_in[ch_idx] = 1'b1;
         end
      end

      if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            REG_ENABLE: begin
               enable_in = csr_bus.data[0];
            end
            REG_DELAY_LENGTH: begin
               dlen_in = csr_bus.data[DLEN_W-1:0];
               wrap_in = '0;
               for (int c = 0; c < CHANNELS; c++) begin
                  pos_in[c] = '0;
               end
            end
            REG_FEEDBACK_GAIN: begin
               gain_in = csr_bus.data[GAIN_W-1:0];
            end
            default: begin
            end
         endcase
      end

      s1_v_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_v_ff);
      s2_v_in  = s1_move ? 1'b1 : (out_load ? 1'b0 : s2_v_ff);
      rsp_v_in = out_load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_v_ff);
   end

   assign csr_bus.ready = 1'b1;

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RESET;
         dlen_ff   <= DLEN_RESET;
         gain_ff   <= GAIN_RESET;
         wrap_ff   <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
         end
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         dlen_ff   <= dlen_in;
         gain_ff   <= gain_in;
         wrap_ff   <= wrap_in;
         pos_ff    <= pos_in;
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff      <= act_new;
         s1_vld_ff      <= wrap_ff[ch_idx];
         // the write leaving stage 2 at this edge misses the RAM read
         s1_fwd_ff      <= wr_en && (s2_addr_ff == addr_new);
         s1_fwd_data_ff <= y_val;
         s1_ch_ff       <= req_bus.channel;
         s1_x_ff        <= req_bus.sample_in;
         s1_addr_ff     <= addr_new;
      end
      if (s1_move) begin
         s2_act_ff  <= s1_act_ff;
         s2_ch_ff   <= s1_ch_ff;
         s2_x_ff    <= s1_x_ff;
         s2_addr_ff <= s1_addr_ff;
         s2_prod_ff <= prod;
      end
      if (out_load) begin
         rsp_ch_ff  <= s2_ch_ff;
         rsp_smp_ff <= y_val;
      end
   end

   assign rsp_bus.valid       = rsp_v_ff;
   assign rsp_bus.channel_out = rsp_ch_ff;
   assign rsp_bus.sample_out  = rsp_smp_ff;

endmodule
